// ----- sv/sab_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, row type and sequencer states for the suffix automaton builder.
// No dependencies.
package sab_pkg;
   localparam int MAX_STATES = 2048;
   localparam int ALPHA_SIZE = 26;
   localparam int ST_W       = $clog2(MAX_STATES);
   localparam int CNT_W      = ST_W + 1;
   localparam int LTR_W      = 5;
   localparam int ROW_W      = ALPHA_SIZE * ST_W;

   // one state's full transition row, one entry per letter
   typedef logic [ALPHA_SIZE-1:0][ST_W-1:0] row_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_WRD,
      ST_WCHK,
      ST_QRD,
      ST_QCHK,
      ST_CLN,
      ST_RRD,
      ST_RCHK,
      ST_FIN,
      ST_DONE
   } seq_state_type;
endpackage

// ----- sv/sab_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module sab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- sv/suffix_automaton_builder_core.sv -----
`timescale 1ns / 1ps
// Suffix automaton builder: sequencer over transition, length and link stores.
// Depends on sab_pkg and sab_ram.
//
//  channel  dir  ports                                         word
//  req      in   req_valid, req_stall, req_letter              one letter
//  rsp      out  rsp_valid, rsp_stall, rsp_new_state .. full   one step result
//
// Each letter walks the suffix links (a read and a check per hop), checks the
// target, makes a clone with its redirect checks when one is needed, and then finishes.
// Ignored letters (store full, letter out of range) go straight to the result.
// The transition store holds one row per state, so a clone copies in a single row write.
// After reset, the root row is cleared before req is taken; rows of new
// states are cleared as they are allocated.
// req_stall is high while a letter is in work; a held result does not block req.
module suffix_automaton_builder_core import sab_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [LTR_W-1:0] req_letter,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [ST_W-1:0]  rsp_new_state,
   output logic [ST_W-1:0]  rsp_new_length,
   output logic [ST_W-1:0]  rsp_new_link,
   output logic             rsp_cloned,
   output logic [ST_W-1:0]  rsp_clone_state,
   output logic [CNT_W-1:0] rsp_state_count,
   output logic             rsp_full_res
);
   seq_state_type state_ff, state_in;

   logic [LTR_W-1:0] letter_ff, letter_in;
   logic [ST_W-1:0]  p_ff, p_in, q_ff, q_in, np_ff, np_in, nq_ff, nq_in;
   logic [ST_W-1:0]  lenp_ff, lenp_in, nlen_ff, nlen_in, link_ff, link_in;
   logic [ST_W-1:0]  highest_ff, highest_in, last_ff, last_in;
   logic             first_ff, first_in, cloned_ff, cloned_in, full_ff, full_in;

   logic             rsp_valid_ff;
   logic [ST_W-1:0]  rsp_ns_ff, rsp_nl_ff, rsp_lk_ff, rsp_cs_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;
   logic             rsp_cl_ff, rsp_full_ff;

   // store ports
   logic            tr_we, len_we, lk_we;
   logic [ST_W-1:0] tr_wa, len_wa, lk_wa, tr_ra, len_ra, lk_ra;
   row_type         tr_wd, tr_rd, row_mod;
   logic [ST_W-1:0] len_wd, lk_wd, len_rd, lk_rd;

   logic [ST_W-1:0] lenp_now, entry;
   logic            accept, out_free;

   sab_ram #(.WIDTH(ROW_W), .DEPTH(MAX_STATES)) u_tr (
      .clock(clock), .wr_en(tr_we), .wr_addr(tr_wa), .wr_data(tr_wd),
      .rd_addr(tr_ra), .rd_data(tr_rd));
   sab_ram #(.WIDTH(ST_W), .DEPTH(MAX_STATES)) u_len (
      .clock(clock), .wr_en(len_we), .wr_addr(len_wa), .wr_data(len_wd),
      .rd_addr(len_ra), .rd_data(len_rd));
   sab_ram #(.WIDTH(ST_W), .DEPTH(MAX_STATES)) u_lk (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
      .rd_addr(lk_ra), .rd_data(lk_rd));

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // root length is fixed at zero and never stored
   assign lenp_now  = (p_ff == '0) ? '0 : len_rd;
   assign entry     = tr_rd[letter_ff];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (highest_ff >= ST_W'(MAX_STATES - 2) || req_letter >= LTR_W'(ALPHA_SIZE)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WRD;
               end
            end
         end
         ST_WRD:  state_in = ST_WCHK;
         ST_WCHK: begin
            if (entry != '0) begin
               state_in = ST_QRD;
            end else if (p_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_WRD;
            end
         end
         ST_QRD:  state_in = ST_QCHK;
         ST_QCHK: state_in = (len_rd == lenp_ff + 1'b1) ? ST_FIN : ST_CLN;
         ST_CLN:  state_in = ST_RRD;
         ST_RRD:  state_in = ST_RCHK;
         ST_RCHK: begin
            if (entry == q_ff && p_ff != '0) begin
               state_in = ST_RRD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_DONE;
         ST_DONE: state_in = out_free ? ST_IDLE : ST_DONE;
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      letter_in  = letter_ff;
      p_in       = p_ff;
      q_in       = q_ff;
      np_in      = np_ff;
      nq_in      = nq_ff;
      lenp_in    = lenp_ff;
      nlen_in    = nlen_ff;
      link_in    = link_ff;
      highest_in = highest_ff;
      last_in    = last_ff;
      first_in   = first_ff;
      cloned_in  = cloned_ff;
      full_in    = full_ff;
      tr_we  = 1'b0;
      tr_wa  = p_ff;
      tr_wd  = '0;
      len_we = 1'b0;
      len_wa = np_ff;
      len_wd = lenp_now + 1'b1;
      lk_we  = 1'b0;
      lk_wa  = np_ff;
      lk_wd  = link_ff;
      tr_ra  = p_ff;
      len_ra = p_ff;
      lk_ra  = p_ff;
      row_mod = tr_rd;
      case (state_ff)
         ST_INIT: begin
            tr_we = 1'b1;
            tr_wa = '0;
         end
         ST_IDLE: begin
            if (accept) begin
               letter_in = req_letter;
               np_in     = '0;
               nq_in     = '0;
               nlen_in   = '0;
               link_in   = '0;
               cloned_in = 1'b0;
               full_in   = (highest_ff >= ST_W'(MAX_STATES - 2));
               if (!(highest_ff >= ST_W'(MAX_STATES - 2))
                   && req_letter < LTR_W'(ALPHA_SIZE)) begin
                  np_in      = highest_ff + 1'b1;
                  highest_in = highest_ff + 1'b1;
                  p_in       = last_ff;
                  first_in   = 1'b1;
                  // fresh row for the new state
                  tr_we = 1'b1;
                  tr_wa = highest_ff + 1'b1;
               end
            end
         end
         ST_WCHK: begin
            lenp_in = lenp_now;
            if (first_ff) begin
               nlen_in  = lenp_now + 1'b1;
               len_we   = 1'b1;
               first_in = 1'b0;
            end
            if (entry != '0) begin
               q_in = entry;
            end else begin
               row_mod[letter_ff] = np_ff;
               tr_we = 1'b1;
               tr_wd = row_mod;
               if (p_ff == '0) begin
                  link_in = '0;
               end else begin
                  p_in = lk_rd;
               end
            end
         end
         ST_QRD: begin
            tr_ra  = q_ff;
            len_ra = q_ff;
            lk_ra  = q_ff;
         end
         ST_QCHK: begin
            if (len_rd == lenp_ff + 1'b1) begin
               link_in = q_ff;
            end else begin
               nq_in      = highest_ff + 1'b1;
               highest_in = highest_ff + 1'b1;
               cloned_in  = 1'b1;
               link_in    = highest_ff + 1'b1;
               tr_we  = 1'b1;
               tr_wa  = highest_ff + 1'b1;
               tr_wd  = tr_rd;
               len_we = 1'b1;
               len_wa = highest_ff + 1'b1;
               len_wd = lenp_ff + 1'b1;
               lk_we  = 1'b1;
               lk_wa  = highest_ff + 1'b1;
               lk_wd  = lk_rd;
            end
         end
         ST_CLN: begin
            lk_we = 1'b1;
            lk_wa = q_ff;
            lk_wd = nq_ff;
         end
         ST_RCHK: begin
            if (entry == q_ff) begin
               row_mod[letter_ff] = nq_ff;
               tr_we = 1'b1;
               tr_wd = row_mod;
               if (p_ff != '0) begin
                  p_in = lk_rd;
               end
            end
         end
         ST_FIN: begin
            lk_we   = 1'b1;
            last_in = np_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         highest_ff   <= '0;
         last_ff      <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         highest_ff <= highest_in;
         last_ff    <= last_in;
         first_ff   <= first_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      np_ff     <= np_in;
      nq_ff     <= nq_in;
      lenp_ff   <= lenp_in;
      nlen_ff   <= nlen_in;
      link_ff   <= link_in;
      cloned_ff <= cloned_in;
      full_ff   <= full_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_ns_ff   <= np_ff;
         rsp_nl_ff   <= nlen_ff;
         rsp_lk_ff   <= link_ff;
         rsp_cl_ff   <= cloned_ff;
         rsp_cs_ff   <= nq_ff;
         rsp_cnt_ff  <= {1'b0, highest_ff} + 1'b1;
         rsp_full_ff <= full_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_state   = rsp_ns_ff;
   assign rsp_new_length  = rsp_nl_ff;
   assign rsp_new_link    = rsp_lk_ff;
   assign rsp_cloned      = rsp_cl_ff;
   assign rsp_clone_state = rsp_cs_ff;
   assign rsp_state_count = rsp_cnt_ff;
   assign rsp_full_res    = rsp_full_ff;

   a_clone_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLN) |-> (cloned_ff && nq_ff == np_ff + 1'b1))
      else $error("clone index not next after new state");
   a_last_in_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (last_ff <= highest_ff))
      else $error("last state beyond highest state");
   a_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && accept && !full_in && req_letter < LTR_W'(ALPHA_SIZE))
      |=> (highest_ff == $past(highest_ff) + 1'b1))
      else $error("new state not allocated");
   a_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result not presented");
endmodule

// ----- tb/sv/suffix_automaton_builder_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for suffix_automaton_builder_core: letters in, one result word out.
// Depends on sab_pkg and the core RTL; it has its own automaton model for expected words.
module suffix_automaton_builder_core_test;
   import sab_pkg::*;

   typedef struct {
      logic [ST_W-1:0]  new_state;
      logic [ST_W-1:0]  new_length;
      logic [ST_W-1:0]  new_link;
      logic             cloned;
      logic [ST_W-1:0]  clone_state;
      logic [CNT_W-1:0] state_count;
      logic             full;
   } step_word_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [LTR_W-1:0] req_letter;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [ST_W-1:0]  rsp_new_state;
   logic [ST_W-1:0]  rsp_new_length;
   logic [ST_W-1:0]  rsp_new_link;
   logic             rsp_cloned;
   logic [ST_W-1:0]  rsp_clone_state;
   logic [CNT_W-1:0] rsp_state_count;
   logic             rsp_full_res;

   // automaton model; link of -1 means none
   logic [ST_W-1:0] goto_tbl [MAX_STATES][ALPHA_SIZE];
   int              len_tbl  [MAX_STATES];
   int              link_tbl [MAX_STATES];
   int              top_state;
   int              tail_state;

   step_word_type pending_steps[$];
   int            err_cnt;
   int            send_idle_pct;
   int            stall_pct;

   suffix_automaton_builder_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_letter(req_letter),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_new_state(rsp_new_state), .rsp_new_length(rsp_new_length),
      .rsp_new_link(rsp_new_link), .rsp_cloned(rsp_cloned),
      .rsp_clone_state(rsp_clone_state), .rsp_state_count(rsp_state_count),
      .rsp_full_res(rsp_full_res)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   task automatic clear_automaton();
      for (int s = 0; s < MAX_STATES; s++) begin
         for (int c = 0; c < ALPHA_SIZE; c++) goto_tbl[s][c] = '0;
         len_tbl[s]  = 0;
         link_tbl[s] = 0;
      end
      link_tbl[0] = -1;
      top_state   = 0;
      tail_state  = 0;
   endtask

   function automatic step_word_type append_letter(input logic [LTR_W-1:0] c);
      step_word_type r;
      int used, p, np, q, nq, lk;
      r = '{default: '0};
      used = top_state + 1;
      r.state_count = CNT_W'(used);
      nq = 0;
      if (MAX_STATES - used < 2) begin
         r.full = 1'b1;
         return r;
      end
      if (c >= ALPHA_SIZE) return r;
      p = tail_state;
      top_state++;
      np = top_state;
      len_tbl[np] = len_tbl[p] + 1;
      while (p != -1 && goto_tbl[p][c] == 0) begin
         goto_tbl[p][c] = ST_W'(np);
         p = link_tbl[p];
      end
      if (p == -1) begin
         lk = 0;
      end else begin
         q = int'(goto_tbl[p][c]);
         if (len_tbl[q] == len_tbl[p] + 1) begin
            lk = q;
         end else begin
            top_state++;
            nq = top_state;
            r.cloned = 1'b1;
            for (int k = 0; k < ALPHA_SIZE; k++) goto_tbl[nq][k] = goto_tbl[q][k];
            len_tbl[nq]  = len_tbl[p] + 1;
            link_tbl[nq] = link_tbl[q];
            link_tbl[q]  = nq;
            lk = nq;
            while (p != -1 && int'(goto_tbl[p][c]) == q) begin
               goto_tbl[p][c] = ST_W'(nq);
               p = link_tbl[p];
            end
         end
      end
      link_tbl[np] = lk;
      tail_state   = np;
      r.new_state   = ST_W'(np);
      r.new_length  = ST_W'(len_tbl[np]);
      r.new_link    = ST_W'(lk);
      r.clone_state = ST_W'(nq);
      r.state_count = CNT_W'(top_state + 1);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t mismatch %s: got %0d want %0d", $time, field, got, want);
      err_cnt++;
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      step_word_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_steps.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               w = pending_steps.pop_front();
               if (rsp_new_state !== w.new_state)
                  report_mismatch("new_state", int'(rsp_new_state), int'(w.new_state));
               if (rsp_new_length !== w.new_length)
                  report_mismatch("new_length", int'(rsp_new_length), int'(w.new_length));
               if (rsp_new_link !== w.new_link)
                  report_mismatch("new_link", int'(rsp_new_link), int'(w.new_link));
               if (rsp_cloned !== w.cloned)
                  report_mismatch("cloned", int'(rsp_cloned), int'(w.cloned));
               if (rsp_clone_state !== w.clone_state)
                  report_mismatch("clone_state", int'(rsp_clone_state),
                                  int'(w.clone_state));
               if (rsp_state_count !== w.state_count)
                  report_mismatch("state_count", int'(rsp_state_count),
                                  int'(w.state_count));
               if (rsp_full_res !== w.full)
                  report_mismatch("full_res", int'(rsp_full_res), int'(w.full));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // called just after a rising edge; leaves req_valid high
   task automatic send_letter(input int c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_letter <= LTR_W'(c);
      do @(posedge clock); while (req_stall);
      pending_steps.push_back(append_letter(LTR_W'(c)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int pick_letter(input int span);
      if ($urandom_range(99) < 4) return int'($urandom_range(31, ALPHA_SIZE));
      return int'($urandom_range(span - 1));
   endfunction

   task automatic test_directed();
      // first letter on empty automaton, alphabet extremes, out of range
      send_letter(0);
      send_letter(ALPHA_SIZE - 1);
      send_letter(ALPHA_SIZE);
      send_letter(31);
      // repeats that force links to existing targets and clones
      send_letter(0); send_letter(0); send_letter(1); send_letter(2);
      send_letter(1); send_letter(2); send_letter(1); send_letter(0);
      send_letter(1); send_letter(0); send_letter(1); send_letter(1);
      send_letter(21); send_letter(10); send_letter(31);
      wait_drained();
   endtask

   task automatic test_random_phase(input int idle, input int stall, input int count);
      int span;
      send_idle_pct = idle;
      stall_pct     = stall;
      for (int i = 0; i < count; i++) begin
         if (i % 30 == 0) span = ($urandom_range(3) == 0) ? ALPHA_SIZE : $urandom_range(4, 2);
         send_letter(pick_letter(span));
      end
      wait_drained();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_letter    = '0;
      err_cnt       = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      clear_automaton();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(0, 0, 110);
      test_random_phase(63, 0, 110);
      test_random_phase(0, 63, 110);
      test_random_phase(38, 38, 110);
      if (err_cnt == 0)
         $display("suffix_automaton_builder_core_test: PASS");
      else
         $display("suffix_automaton_builder_core_test: FAIL");
      $finish;
   end

   initial begin
      #50ms;
      $display("suffix_automaton_builder_core_test: FAIL");
      $finish;
   end
endmodule
